// ----- rtl/clnw_pkg.sv -----
// ----------------------------------------------------------------------------
// clnw_pkg
// Shared types and constants of the character LCD nibble writer.
// ----------------------------------------------------------------------------
package clnw_pkg;

    // request codes
    localparam logic [3:0] REQ_CHAR     = 4'd0;
    localparam logic [3:0] REQ_COMMAND  = 4'd1;
    localparam logic [3:0] REQ_POSITION = 4'd2;
    localparam logic [3:0] REQ_HOME     = 4'd3;
    localparam logic [3:0] REQ_CLEAR    = 4'd4;
    localparam logic [3:0] REQ_DISPLAY  = 4'd5;
    localparam logic [3:0] REQ_CURSOR   = 4'd6;
    localparam logic [3:0] REQ_BLINK    = 4'd7;
    localparam logic [3:0] REQ_INIT     = 4'd8;

    // configuration register indexes
    localparam logic [1:0] CFG_COL_COUNT     = 2'd0;
    localparam logic [1:0] CFG_ROW_COUNT     = 2'd1;
    localparam logic [1:0] CFG_BUS_EIGHT_BIT = 2'd2;

    localparam int CFG_DATA_W = 6;

    localparam logic [5:0] COL_COUNT_RESET = 6'd16;
    localparam logic [1:0] ROW_COUNT_RESET = 2'd2;

    // lcd command bytes and masks
    localparam logic [7:0] SET_ADDR_CMD = 8'h80;
    localparam logic [7:0] ROW_OFFSET   = 8'h40;
    localparam logic [7:0] NIBBLE_MASK  = 8'h0F;
    localparam logic [7:0] CLEAR_CMD    = 8'h01;
    localparam logic [7:0] HOME_CMD     = 8'h02;
    localparam logic [7:0] CTRL_CMD     = 8'h08;
    localparam logic [2:0] DISP_BIT     = 3'h4;
    localparam logic [2:0] CURS_BIT     = 3'h2;
    localparam logic [2:0] BLINK_BIT    = 3'h1;

    localparam logic [2:0] SETTLE_NONE = 3'd0;
    localparam logic [2:0] SETTLE_CMD  = 3'd2;
    localparam logic [2:0] SETTLE_HOME = 3'd5;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [3:0] req_type;
        logic [7:0] byte_value;
        logic [5:0] pos_x;
        logic [1:0] pos_y;
        logic       flag_on;
    } in_t;

    typedef struct packed {
        logic       reg_select;
        logic [7:0] bus_bits;
        logic [2:0] settle_ms;
        logic       last_transfer;
    } out_t;

    typedef struct packed {
        logic       rs;
        logic [7:0] value;
        logic [2:0] settle;
    } lcd_byte_t;

    // one classified request: one or two bytes to put on the bus
    typedef struct packed {
        logic      two_bytes;
        logic      eight_bit;
        logic      nibble_only;
        lcd_byte_t first;
        lcd_byte_t second;
    } job_t;

    typedef struct packed {
        logic [5:0] col_count;
        logic [1:0] row_count;
        logic       bus_eight_bit;
    } cfg_t;

endpackage

// ----- rtl/clnw_front.sv -----
// ----------------------------------------------------------------------------
// clnw_front
// Accepts requests, tracks cursor and control bits, turns each request into
// a job of one or two bus bytes; out-of-range positions and unknown types give none.
// ----------------------------------------------------------------------------
module clnw_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  clnw_pkg::cfg_t cfg,
    input  logic           s_valid,
    output logic           s_ready,
    input  clnw_pkg::in_t  s_data,
    input  logic           q_full,
    output logic           q_push,
    output clnw_pkg::job_t q_job
);

    logic [5:0] col_reg, col_next;
    logic [1:0] row_reg, row_next;
    logic [2:0] ctrl_reg, ctrl_next;
    logic       has_job;
    logic       accept;
    logic [5:0] col_inc;
    logic [1:0] row_inc;
    logic [1:0] wrap_row;
    logic [2:0] ctrl_bit;
    logic [2:0] ctrl_new;
    logic [7:0] pos_cmd;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign q_push  = accept && has_job;

    always_comb begin
        col_inc  = col_reg + 6'd1;
        row_inc  = row_reg + 2'd1;
        wrap_row = (row_inc == cfg.row_count) ? 2'd0 : row_inc;
        pos_cmd  = {2'b00, s_data.pos_x}
                 + (clnw_pkg::SET_ADDR_CMD
                    | ((s_data.pos_y != 2'd0) ? clnw_pkg::ROW_OFFSET : 8'h00));

        case (s_data.req_type)
            clnw_pkg::REQ_DISPLAY: ctrl_bit = clnw_pkg::DISP_BIT;
            clnw_pkg::REQ_CURSOR:  ctrl_bit = clnw_pkg::CURS_BIT;
            default:               ctrl_bit = clnw_pkg::BLINK_BIT;
        endcase
        ctrl_new = s_data.flag_on ? (ctrl_reg | ctrl_bit) : (ctrl_reg & ~ctrl_bit);

        col_next  = col_reg;
        row_next  = row_reg;
        ctrl_next = ctrl_reg;
        has_job   = 1'b1;
        q_job     = '0;
        q_job.eight_bit = cfg.bus_eight_bit;

        case (s_data.req_type)
            clnw_pkg::REQ_CHAR: begin
                q_job.first = '{1'b1, s_data.byte_value, clnw_pkg::SETTLE_NONE};
                col_next = col_inc;
                if (col_inc == cfg.col_count) begin
                    col_next = 6'd0;
                    row_next = wrap_row;
                    q_job.two_bytes = 1'b1;
                    q_job.second = '{1'b0,
                        clnw_pkg::SET_ADDR_CMD
                        | ((wrap_row != 2'd0) ? clnw_pkg::ROW_OFFSET : 8'h00),
                        clnw_pkg::SETTLE_CMD};
                end
            end
            clnw_pkg::REQ_COMMAND: begin
                q_job.first = '{1'b0, s_data.byte_value, clnw_pkg::SETTLE_CMD};
            end
            clnw_pkg::REQ_POSITION: begin
                if (s_data.pos_x >= cfg.col_count || s_data.pos_y >= cfg.row_count) begin
                    has_job = 1'b0;
                end else begin
                    q_job.first = '{1'b0, pos_cmd, clnw_pkg::SETTLE_CMD};
                    col_next = s_data.pos_x;
                    row_next = s_data.pos_y;
                end
            end
            clnw_pkg::REQ_HOME: begin
                q_job.first = '{1'b0, clnw_pkg::HOME_CMD, clnw_pkg::SETTLE_HOME};
                col_next = 6'd0;
                row_next = 2'd0;
            end
            clnw_pkg::REQ_CLEAR: begin
                q_job.two_bytes = 1'b1;
                q_job.first  = '{1'b0, clnw_pkg::CLEAR_CMD, clnw_pkg::SETTLE_CMD};
                q_job.second = '{1'b0, clnw_pkg::HOME_CMD, clnw_pkg::SETTLE_HOME};
                col_next = 6'd0;
                row_next = 2'd0;
            end
            clnw_pkg::REQ_DISPLAY, clnw_pkg::REQ_CURSOR, clnw_pkg::REQ_BLINK: begin
                ctrl_next = ctrl_new;
                q_job.first = '{1'b0, clnw_pkg::CTRL_CMD | {5'd0, ctrl_new},
                                clnw_pkg::SETTLE_CMD};
            end
            clnw_pkg::REQ_INIT: begin
                q_job.nibble_only = 1'b1;
                q_job.first = '{1'b0, s_data.byte_value & clnw_pkg::NIBBLE_MASK,
                                clnw_pkg::SETTLE_NONE};
            end
            default: begin
                has_job = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= 6'd0;
            row_reg  <= 2'd0;
            ctrl_reg <= 3'd0;
        end else if (accept) begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            ctrl_reg <= ctrl_next;
        end
    end

endmodule

// ----- rtl/clnw_queue.sv -----
// ----------------------------------------------------------------------------
// clnw_queue
// Short job queue between the front and the bus sequencer.
// ----------------------------------------------------------------------------
module clnw_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  clnw_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output clnw_pkg::job_t head_job
);

    clnw_pkg::job_t                 mem_reg [clnw_pkg::QUEUE_DEPTH];
    logic [clnw_pkg::QPTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [clnw_pkg::QPTR_W:0]      count_reg, count_next;

    assign full       = (count_reg == (clnw_pkg::QPTR_W+1)'(clnw_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

// ----- rtl/clnw_back.sv -----
// ----------------------------------------------------------------------------
// clnw_back
// Bus sequencer: splits each job into strobes, one per cycle while m_ready
// does not stall the output, into an output register.
// ----------------------------------------------------------------------------
module clnw_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           head_valid,
    input  clnw_pkg::job_t head_job,
    output logic           pop,
    output logic           m_valid,
    input  logic           m_ready,
    output clnw_pkg::out_t m_data
);

    logic               sel_reg;   // which byte of the job
    logic               half_reg;  // low nibble pending
    logic               m_valid_reg;
    clnw_pkg::out_t     m_data_reg, m_data_next;
    clnw_pkg::lcd_byte_t cur;
    logic               single;
    logic               byte_done;
    logic               job_done;
    logic               load;

    assign load    = head_valid && (!m_valid_reg || m_ready);
    assign pop     = load && job_done;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        cur       = sel_reg ? head_job.second : head_job.first;
        single    = head_job.eight_bit || head_job.nibble_only;
        byte_done = single || half_reg;
        job_done  = byte_done && (sel_reg || !head_job.two_bytes);

        m_data_next.reg_select    = cur.rs;
        m_data_next.last_transfer = job_done;
        if (single) begin
            m_data_next.bus_bits  = cur.value;
            m_data_next.settle_ms = cur.settle;
        end else if (!half_reg) begin
            m_data_next.bus_bits  = {4'd0, cur.value[7:4]};
            m_data_next.settle_ms = clnw_pkg::SETTLE_NONE;
        end else begin
            m_data_next.bus_bits  = cur.value & clnw_pkg::NIBBLE_MASK;
            m_data_next.settle_ms = cur.settle;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg <= m_data_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg     <= 1'b0;
            half_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                m_valid_reg <= 1'b1;
                half_reg    <= !byte_done;
                if (byte_done) begin
                    sel_reg <= !job_done;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ----- rtl/char_lcd_nibble_writer.sv -----
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer
// Character LCD request to bus strobe converter, 4-bit or 8-bit bus.
// ----------------------------------------------------------------------------
//  channel   dir   handshake            payload
//  s_        in    s_valid / s_ready    clnw_pkg::in_t  request
//  m_        out   m_valid / m_ready    clnw_pkg::out_t one strobe
//  cfg_      in    cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  a request gives 0 to 4 strobes, one per cycle unless m_ready holds the
//  output; rejected positions and unknown types give none.
//  the front takes a request every cycle while the 4-entry job queue has
//  room. m_valid rises once the queue, then the output register, take the job.
//  synchronous reset clears cursor, control bits, queue and output valid;
//  config resets to 16 columns, 2 rows, 4-bit bus. cfg_ready is always high.
//  m_ready low holds the output register, then the queue, then s_ready.
// ----------------------------------------------------------------------------
module char_lcd_nibble_writer (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  clnw_pkg::in_t                   s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output clnw_pkg::out_t                  m_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [1:0]                      cfg_index,
    input  logic [clnw_pkg::CFG_DATA_W-1:0] cfg_data
);

    clnw_pkg::cfg_t cfg_reg;
    clnw_pkg::job_t push_job, head_job;
    logic           push, full, pop, head_valid;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.col_count     <= clnw_pkg::COL_COUNT_RESET;
            cfg_reg.row_count     <= clnw_pkg::ROW_COUNT_RESET;
            cfg_reg.bus_eight_bit <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                clnw_pkg::CFG_COL_COUNT:     cfg_reg.col_count     <= cfg_data;
                clnw_pkg::CFG_ROW_COUNT:     cfg_reg.row_count     <= cfg_data[1:0];
                clnw_pkg::CFG_BUS_EIGHT_BIT: cfg_reg.bus_eight_bit <= cfg_data[0];
                default: ;
            endcase
        end
    end

    clnw_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (full),
        .q_push  (push),
        .q_job   (push_job)
    );

    clnw_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_job   (push_job),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    clnw_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

// ----- rtl/clnw_checker.sv -----
// ----------------------------------------------------------------------------
// clnw_checker
// Port-level checks of the character LCD nibble writer.
// ----------------------------------------------------------------------------
module clnw_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           m_valid,
    input logic           m_ready,
    input clnw_pkg::out_t m_data
);

    // a stalled strobe holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("strobe changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("strobe valid right after reset");

    // data register strobes never need settle time
    a_data_settle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.reg_select |-> m_data.settle_ms == clnw_pkg::SETTLE_NONE)
        else $error("data strobe with settle time");

    a_settle_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.settle_ms <= clnw_pkg::SETTLE_HOME)
        else $error("settle time out of range");

endmodule

bind char_lcd_nibble_writer clnw_checker u_clnw_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
